FILE: rtl/core/csf_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the course/speed block.
// No dependencies.
package csf_pkg;

    localparam int TIME_W            = 47;
    localparam int MPU_W             = 24;
    localparam int COURSE_W          = 16;
    localparam int SPEED_W           = 24;
    localparam int OUT_TDATA_W       = 40;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_COORD_BITS    = 24;
    localparam int QUOT_W            = 24;

    localparam logic [MPU_W-1:0]   MPU_RESET   = 24'd65536;
    localparam logic [23:0]        INV_GAIN    = 24'd10188014;
    localparam logic [21:0]        MS_PER_HOUR = 22'd3600000;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic              tv;
        logic              zero;
        logic [TIME_W-1:0] dt;
    } meta_t;

    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/course_speed_from_two_fixes.sv
// Course and speed from two timed fixes: one beat per cycle sustained while the skid
// stage is empty, set by the fully pipelined CORDIC and divider. Output register plus
// skid stage decouple stalls; a full skid stage stalls the whole pipeline and input.
// Asynchronous active-low reset empties the pipeline and sets miles_per_unit to 1.0.
// Top level; depends on csf_pkg, csf_cordic, csf_divider.
module course_speed_from_two_fixes #(
    parameter int CORDIC_STAGES = csf_pkg::DEF_CORDIC_STAGES,
    parameter int COORD_BITS    = csf_pkg::DEF_COORD_BITS,
    parameter int IN_W          = ((4 * COORD_BITS + 2 * csf_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // start_x, start_y, start_time, end_x, end_y, end_time
    input  logic [IN_W-1:0]                    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // course, speed
    output logic [csf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // valid_res
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [csf_pkg::MPU_W-1:0]          cfg_tdata,
    input  logic                               cfg_tvalid,
    output logic                               cfg_tready
);

    localparam int TW   = csf_pkg::TIME_W;
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int CW   = CB + 11;
    localparam int XU   = CB + 2;
    localparam int PW   = XU + 24;
    localparam int AW   = XU + csf_pkg::MPU_W;
    localparam int HIW  = AW - 25;
    localparam int NUMW = AW + 22;
    localparam int NW   = NUMW - 16;
    localparam int MW   = $bits(csf_pkg::meta_t);
    localparam int DTAG = 2 + csf_pkg::COURSE_W;

    logic en;
    logic [csf_pkg::MPU_W-1:0] mpu_reg;

    // input field slices
    logic signed [CB-1:0] sx, sy, ex, ey;
    logic [TW-1:0]        st, et;
    assign sx = s_tdata[CB-1:0];
    assign sy = s_tdata[2*CB-1:CB];
    assign st = s_tdata[2*CB+TW-1:2*CB];
    assign ex = s_tdata[3*CB+TW-1:2*CB+TW];
    assign ey = s_tdata[4*CB+TW-1:3*CB+TW];
    assign et = s_tdata[4*CB+2*TW-1:4*CB+TW];

    assign cfg_tready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mpu_reg <= csf_pkg::MPU_RESET;
        else if (cfg_tvalid)
            mpu_reg <= cfg_tdata;
    end

    // stage 0: differences
    logic                 v0_reg;
    logic signed [DW-1:0] dx0_reg, dy0_reg;
    logic                 tv0_reg;
    logic [TW-1:0]        dt0_reg;

    // stage 1: pre-rotation into right half plane
    logic                 v1_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;
    logic [31:0]          z1_reg;
    csf_pkg::meta_t       m1_reg;

    logic signed [CW-1:0] dxs, dys;
    assign dxs = CW'(dx0_reg) <<< 8;
    assign dys = CW'(dy0_reg) <<< 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg <= DW'(ex) - DW'(sx);
            dy0_reg <= DW'(ey) - DW'(sy);
            tv0_reg <= (et > st);
            dt0_reg <= et - st;
            x1_reg  <= dy0_reg[DW-1] ? -dys : dys;
            y1_reg  <= dy0_reg[DW-1] ? -dxs : dxs;
            z1_reg  <= dy0_reg[DW-1] ? 32'h8000_0000 : 32'h0;
            m1_reg.tv   <= tv0_reg;
            m1_reg.zero <= (dx0_reg == '0) && (dy0_reg == '0);
            m1_reg.dt   <= dt0_reg;
        end
    end

    logic                 cv;
    logic signed [CW-1:0] cx;
    logic [31:0]          cz;
    logic [MW-1:0]        ctag;

    csf_cordic #(
        .STAGES (CORDIC_STAGES),
        .CW     (CW),
        .TAG_W  (MW)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_x      (x1_reg),
        .in_y      (y1_reg),
        .in_z      (z1_reg),
        .in_tag    (m1_reg),
        .out_valid (cv),
        .out_x     (cx),
        .out_z     (cz),
        .out_tag   (ctag)
    );

    // magnitude and scaling stages
    logic                          v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    csf_pkg::meta_t                m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    logic [csf_pkg::COURSE_W-1:0]  c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;
    logic [XU-1:0]                 xc2_reg;
    logic [PW-1:0]                 p3_reg;
    logic [XU-1:0]                 d4_reg;
    logic [AW-1:0]                 a5_reg;
    logic [46:0]                   lo6_reg;
    logic [HIW+21:0]               hi6_reg;
    logic [NW-1:0]                 n7_reg;

    logic [CW-1:0]   xr;
    logic [31:0]     zr;
    logic [PW:0]     pr;
    logic [NUMW-1:0] num;
    assign xr  = cx + CW'(128);
    assign zr  = cz + 32'h8000;
    assign pr  = {1'b0, p3_reg} + (PW+1)'(24'h800000);
    assign num = NUMW'(lo6_reg) + (NUMW'(hi6_reg) << 25);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= cv;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg  <= ctag;
            c2_reg  <= zr[31:16];
            xc2_reg <= xr[CW-1] ? '0 : xr[XU+7:8];
            m3_reg  <= m2_reg;
            c3_reg  <= c2_reg;
            p3_reg  <= PW'(xc2_reg * csf_pkg::INV_GAIN);
            m4_reg  <= m3_reg;
            c4_reg  <= c3_reg;
            d4_reg  <= pr[PW-1:24];
            m5_reg  <= m4_reg;
            c5_reg  <= c4_reg;
            a5_reg  <= AW'(d4_reg * mpu_reg);
            m6_reg  <= m5_reg;
            c6_reg  <= c5_reg;
            lo6_reg <= 47'(a5_reg[24:0] * csf_pkg::MS_PER_HOUR);
            hi6_reg <= (HIW+22)'(a5_reg[AW-1:25] * csf_pkg::MS_PER_HOUR);
            m7_reg  <= m6_reg;
            c7_reg  <= c6_reg;
            n7_reg  <= num[NUMW-1:16];
        end
    end

    logic                          dv, dsat;
    logic [csf_pkg::QUOT_W-1:0]    dq;
    logic [DTAG-1:0]               dtag;

    csf_divider #(
        .NW    (NW),
        .TAG_W (DTAG)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_num    (n7_reg),
        .in_den    (m7_reg.dt),
        .in_tag    ({m7_reg.tv, m7_reg.zero, c7_reg}),
        .out_valid (dv),
        .out_q     (dq),
        .out_sat   (dsat),
        .out_tag   (dtag)
    );

    logic                          r_tv, r_ok;
    logic [csf_pkg::OUT_TDATA_W:0] res;
    assign r_tv = dtag[DTAG-1];
    assign r_ok = r_tv && !dtag[DTAG-2];
    assign res  = {r_tv,
                   r_ok ? (dsat ? csf_pkg::SPEED_MAX : dq) : '0,
                   r_ok ? dtag[csf_pkg::COURSE_W-1:0] : '0};

    // output register and skid stage
    logic                          out_v_reg, skid_v_reg;
    logic [csf_pkg::OUT_TDATA_W:0] out_reg, skid_reg;
    logic                          out_free;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign out_free = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (out_free)
            out_v_reg <= dv;
        else
            skid_v_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (out_free)
            out_reg <= res;
        else
            skid_reg <= res;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg[csf_pkg::OUT_TDATA_W-1:0];
    assign m_tuser  = out_reg[csf_pkg::OUT_TDATA_W];

endmodule

FILE: rtl/core/csf_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage, with a side tag.
// Uses csf_pkg (arctangent table).
module csf_cordic #(
    parameter int STAGES = csf_pkg::DEF_CORDIC_STAGES,
    parameter int CW     = 35,
    parameter int TAG_W  = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic [31:0]          in_z,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic [31:0]          out_z,
    output logic [TAG_W-1:0]     out_tag
);

    logic                 valid_reg [STAGES];
    logic signed [CW-1:0] x_reg     [STAGES];
    logic signed [CW-1:0] y_reg     [STAGES];
    logic [31:0]          z_reg     [STAGES];
    logic [TAG_W-1:0]     tag_reg   [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 v_prev;
        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic [31:0]          z_prev;
        logic [TAG_W-1:0]     t_prev;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic [31:0]          z_next;

        if (k == 0) begin : g_first
            assign v_prev = in_valid;
            assign x_prev = in_x;
            assign y_prev = in_y;
            assign z_prev = in_z;
            assign t_prev = in_tag;
        end else begin : g_next
            assign v_prev = valid_reg[k-1];
            assign x_prev = x_reg[k-1];
            assign y_prev = y_reg[k-1];
            assign z_prev = z_reg[k-1];
            assign t_prev = tag_reg[k-1];
        end

        always_comb
        begin
            if (!y_prev[CW-1])
            begin
                x_next = x_prev + (y_prev >>> k);
                y_next = y_prev - (x_prev >>> k);
                z_next = z_prev + csf_pkg::atan_val(k);
            end
            else
            begin
                x_next = x_prev - (y_prev >>> k);
                y_next = y_prev + (x_prev >>> k);
                z_next = z_prev - csf_pkg::atan_val(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                z_reg[k]   <= z_next;
                tag_reg[k] <= t_prev;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_z     = z_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

FILE: rtl/core/csf_divider.sv
// Pipelined restoring divider, one quotient bit per stage, flagging quotients that overflow 24 bits.
// Uses csf_pkg (time and quotient widths).
module csf_divider #(
    parameter int NW    = 56,
    parameter int TAG_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [NW-1:0]                in_num,
    input  logic [csf_pkg::TIME_W-1:0]   in_den,
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_valid,
    output logic [csf_pkg::QUOT_W-1:0]   out_q,
    output logic                         out_sat,
    output logic [TAG_W-1:0]             out_tag
);

    localparam int QW   = csf_pkg::QUOT_W;
    localparam int TW   = csf_pkg::TIME_W;
    localparam int HW   = NW - QW;
    localparam int CMPW = (HW > TW) ? HW : TW;
    localparam int RW   = TW + 1;

    logic              valid_reg [QW+1];
    logic [RW-1:0]     rem_reg   [QW+1];
    logic [QW-1:0]     low_reg   [QW+1];
    logic [QW-1:0]     q_reg     [QW+1];
    logic [TW-1:0]     den_reg   [QW+1];
    logic              sat_reg   [QW+1];
    logic [TAG_W-1:0]  tag_reg   [QW+1];

    logic [CMPW-1:0] hi_ext;
    logic [CMPW-1:0] den_ext;

    assign hi_ext  = CMPW'(in_num[NW-1:QW]);
    assign den_ext = CMPW'(in_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= (hi_ext >= den_ext);
            rem_reg[0] <= RW'(hi_ext);
            low_reg[0] <= in_num[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [RW-1:0] r2;
        logic          take;

        assign r2   = {rem_reg[k-1][RW-2:0], low_reg[k-1][B]};
        assign take = (r2 >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]    <= take ? (r2 - {1'b0, den_reg[k-1]}) : r2;
                q_reg[k]      <= q_reg[k-1] | (QW'(take) << B);
                low_reg[k]    <= low_reg[k-1];
                den_reg[k]    <= den_reg[k-1];
                sat_reg[k]    <= sat_reg[k-1];
                tag_reg[k]    <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_q     = q_reg[QW];
    assign out_sat   = sat_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

FILE: rtl/core/csf_checker.sv
// Port-level checks for the course/speed block, bound to the top level.
// Uses csf_pkg (output width).
module csf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [csf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result carries nonzero data");

    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid || rst_n)
        else $error("output valid right after reset");

endmodule

bind course_speed_from_two_fixes csf_checker u_csf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
